@@ hw/rtl/kmp_pkg.sv @@
// ----------------------------------------------------------------------------
// kmp_pkg
// Types and constants shared by the KMP substring search unit.
// ----------------------------------------------------------------------------
package kmp_pkg;

  // Pattern/table store geometry: index 0 is never used
  localparam int STORE_DEPTH = 256;
  localparam int ADDR_W      = 8;
  localparam int CHAR_W      = 8;
  localparam int POS_W       = 16;
  localparam int ENTRY_W     = 2 * CHAR_W;
  localparam int LEN_MAX     = STORE_DEPTH - 1;

  // Command op codes
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // One input item
  typedef struct packed {
    logic              op;
    logic [CHAR_W-1:0] data_byte;
    logic              last_text;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } result_t;

  // Store entry: pattern byte in the upper half, nextval link in the lower
  typedef struct packed {
    logic [CHAR_W-1:0] pat;
    logic [CHAR_W-1:0] link;
  } entry_t;

  // Store access from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mem_req_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_BINIT0,
    S_BINIT1,
    S_BCHK,
    S_BCMP,
    S_BADV,
    S_TISSUE,
    S_TCMP
  } state_t;

endpackage

@@ hw/rtl/kmp_ram.sv @@
// ----------------------------------------------------------------------------
// kmp_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module kmp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ hw/rtl/kmp_seq.sv @@
// ----------------------------------------------------------------------------
// kmp_seq
// Sequencer: pattern load, nextval table build and KMP text matching,
// all through the shared pattern/link store.
// ----------------------------------------------------------------------------
module kmp_seq #(
  parameter int MAX_PATTERN = 255
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  kmp_pkg::cmd_t            cmd,
  input  logic [kmp_pkg::POS_W-1:0] first_pos,
  output logic                     busy,
  output logic                     result_valid,
  output kmp_pkg::result_t         result,
  output kmp_pkg::mem_req_t        mem_req,
  input  kmp_pkg::entry_t          rdata_a,
  input  kmp_pkg::entry_t          rdata_b
);
  import kmp_pkg::*;

  // Pattern length cap, never beyond the store
  localparam logic [ADDR_W-1:0] CAP =
    (MAX_PATTERN > LEN_MAX) ? ADDR_W'(LEN_MAX) : ADDR_W'(MAX_PATTERN);
  localparam logic [POS_W-1:0] POS_SAT = {POS_W{1'b1}};

  state_t              state, state_next;
  logic [ADDR_W-1:0]   pattern_len, pattern_len_next;
  logic [ADDR_W:0]     match_len, match_len_next;
  logic [POS_W-1:0]    text_pos, text_pos_next;
  logic                table_ready, table_ready_next;
  logic                search_done, search_done_next;
  logic [CHAR_W-1:0]   cur_byte, cur_byte_next;
  logic                cur_last, cur_last_next;
  logic [ADDR_W-1:0]   bi, bi_next;
  logic [ADDR_W-1:0]   bj, bj_next;
  logic                result_valid_next;
  result_t             result_next;
  logic                new_pattern;
  logic [ADDR_W-1:0]   len_base;

  assign busy        = (state != S_IDLE);
  assign new_pattern = table_ready || search_done;
  assign len_base    = new_pattern ? '0 : pattern_len;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pattern_len  <= '0;
      match_len    <= (ADDR_W+1)'(1);
      text_pos     <= '0;
      table_ready  <= 1'b0;
      search_done  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      pattern_len  <= pattern_len_next;
      match_len    <= match_len_next;
      text_pos     <= text_pos_next;
      table_ready  <= table_ready_next;
      search_done  <= search_done_next;
      result_valid <= result_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_byte <= cur_byte_next;
    cur_last <= cur_last_next;
    bi       <= bi_next;
    bj       <= bj_next;
    result   <= result_next;
  end

  // Next state, store access and results
  always_comb begin
    logic [ADDR_W:0] m_step;
    logic            have_step;
    logic            hit;
    logic            fin;
    logic [POS_W-1:0] hit_pos;

    m_step            = '0;
    have_step         = 1'b0;
    hit               = 1'b0;
    fin               = 1'b0;
    hit_pos           = '0;
    state_next        = state;
    pattern_len_next  = pattern_len;
    match_len_next    = match_len;
    text_pos_next     = text_pos;
    table_ready_next  = table_ready;
    search_done_next  = search_done;
    cur_byte_next     = cur_byte;
    cur_last_next     = cur_last;
    bi_next           = bi;
    bj_next           = bj;
    result_valid_next = 1'b0;
    result_next       = result;
    mem_req           = '0;
    mem_req.raddr_a   = match_len[ADDR_W-1:0];
    mem_req.raddr_b   = bj;

    case (state)
      S_IDLE: begin
        if (start) begin
          if (cmd.op == OP_PATTERN) begin
            // append, restarting the pattern after a build or a match
            if (new_pattern) begin
              table_ready_next = 1'b0;
              search_done_next = 1'b0;
              match_len_next   = (ADDR_W+1)'(1);
              text_pos_next    = '0;
            end
            pattern_len_next = len_base;
            if (len_base < CAP) begin
              pattern_len_next  = len_base + 1'b1;
              mem_req.we        = 1'b1;
              mem_req.waddr     = len_base + 1'b1;
              mem_req.wdata.pat = cmd.data_byte;
            end
          end else if (!search_done) begin
            cur_byte_next = cmd.data_byte;
            cur_last_next = cmd.last_text;
            if (text_pos != POS_SAT) begin
              text_pos_next = text_pos + 1'b1;
            end
            // store read at match_len is already issued
            state_next = table_ready ? S_TCMP : S_BINIT0;
          end
        end
      end

      // link of entry 1 is zero; keep its pattern byte
      S_BINIT0: begin
        mem_req.raddr_a = ADDR_W'(1);
        state_next      = S_BINIT1;
      end

      S_BINIT1: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = ADDR_W'(1);
        mem_req.wdata.pat  = rdata_a.pat;
        mem_req.wdata.link = '0;
        bi_next            = ADDR_W'(1);
        bj_next            = '0;
        state_next         = S_BCHK;
      end

      S_BCHK: begin
        if (bi >= pattern_len) begin
          table_ready_next = 1'b1;
          state_next       = S_TISSUE;
        end else if (bj == '0) begin
          bi_next         = bi + 1'b1;
          bj_next         = ADDR_W'(1);
          mem_req.raddr_a = bi + 1'b1;
          mem_req.raddr_b = ADDR_W'(1);
          state_next      = S_BADV;
        end else begin
          mem_req.raddr_a = bi;
          mem_req.raddr_b = bj;
          state_next      = S_BCMP;
        end
      end

      S_BCMP: begin
        if (rdata_a.pat == rdata_b.pat) begin
          bi_next         = bi + 1'b1;
          bj_next         = bj + 1'b1;
          mem_req.raddr_a = bi + 1'b1;
          mem_req.raddr_b = bj + 1'b1;
          state_next      = S_BADV;
        end else begin
          bj_next    = rdata_b.link;
          state_next = S_BCHK;
        end
      end

      // nextval: skip the link when it leads to the same byte
      S_BADV: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = bi;
        mem_req.wdata.pat  = rdata_a.pat;
        mem_req.wdata.link = (rdata_a.pat != rdata_b.pat) ? bj : rdata_b.link;
        state_next         = S_BCHK;
      end

      S_TISSUE: begin
        state_next = S_TCMP;
      end

      S_TCMP: begin
        if (text_pos < first_pos) begin
          fin = 1'b1;
        end else if (pattern_len == '0) begin
          hit     = 1'b1;
          hit_pos = text_pos;
        end else if (rdata_a.pat == cur_byte) begin
          m_step    = match_len + 1'b1;
          have_step = 1'b1;
        end else if (rdata_a.link == '0) begin
          m_step    = (ADDR_W+1)'(1);
          have_step = 1'b1;
        end else begin
          // follow the failure link, read issued now
          match_len_next  = {1'b0, rdata_a.link};
          mem_req.raddr_a = rdata_a.link;
        end

        if (have_step) begin
          match_len_next = m_step;
          if (m_step > {1'b0, pattern_len}) begin
            hit     = 1'b1;
            hit_pos = text_pos + 1'b1 - POS_W'(pattern_len);
          end else begin
            fin = 1'b1;
          end
        end

        if (hit) begin
          search_done_next  = 1'b1;
          result_valid_next = 1'b1;
          result_next       = '{found: 1'b1, position: hit_pos};
          state_next        = S_IDLE;
        end else if (fin) begin
          state_next = S_IDLE;
          if (cur_last) begin
            result_valid_next = 1'b1;
            result_next       = '{found: 1'b0, position: '0};
            text_pos_next     = '0;
            match_len_next    = (ADDR_W+1)'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Results only come out of the compare step
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_TCMP))
    else $error("result without a compare step");

  // Compare step never runs on an unbuilt table
  a_tcmp_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_TCMP) |-> table_ready)
    else $error("text compare before table build");

  // Next compare index is never zero
  a_match_nz: assert property (@(posedge clk) disable iff (rst)
    match_len != '0)
    else $error("match index zero");

  // Build prefix index stays behind the scan index
  a_build_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_BCHK) |-> (bj < bi))
    else $error("build index order broken");

  // A match is only cleared by a pattern item
  a_done_clear: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(search_done)) |->
      $past(start && !busy && (cmd.op == OP_PATTERN)))
    else $error("search_done cleared without a pattern item");

endmodule

@@ hw/rtl/kmp_substring_search_unit.sv @@
// ----------------------------------------------------------------------------
// kmp_substring_search_unit
// KMP substring search with a nextval failure table held beside the
// pattern in one on-chip store.
//
//   channel  direction  signals                   handshake
//   command  in         start, cmd, busy          taken when start & !busy
//   result   out        result_valid, result      one-cycle strobe
//   config   in         cfg_we, cfg_data          written when cfg_we
//
// A pattern byte is taken in S_IDLE. A text byte passes S_IDLE and S_TCMP,
// which repeats per failure-link step, each step being one read of the store.
// The first text byte after a load adds the table build: S_BINIT0, S_BINIT1,
// then S_BCHK with S_BADV per link write (after S_BCMP when it follows a byte
// compare) and S_BCMP per fallback, ending in S_TISSUE.
// Reset clears control state only; the store needs no clearing pass.
// The result is shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module kmp_substring_search_unit #(
  parameter int MAX_PATTERN = 255
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  kmp_pkg::cmd_t             cmd,
  output logic                      busy,
  output logic                      result_valid,
  output kmp_pkg::result_t          result,
  input  logic                      cfg_we,
  input  logic [kmp_pkg::POS_W-1:0] cfg_data
);
  import kmp_pkg::*;

  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] first_pos;
  mem_req_t         mem_req;
  entry_t           rdata_a;
  entry_t           rdata_b;

  // Start position register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pos <= POS_W'(1);
    end else if (cfg_we) begin
      start_pos <= cfg_data;
    end
  end

  // Position zero behaves like one
  assign first_pos = (start_pos == '0) ? POS_W'(1) : start_pos;

  kmp_seq #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .first_pos    (first_pos),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .mem_req      (mem_req),
    .rdata_a      (rdata_a),
    .rdata_b      (rdata_b)
  );

  // Pattern and link store
  kmp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (mem_req.we),
    .waddr   (mem_req.waddr),
    .wdata   (mem_req.wdata),
    .raddr_a (mem_req.raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (mem_req.raddr_b),
    .rdata_b (rdata_b)
  );

endmodule

@@ bench/kmp_substring_search_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_substring_search_unit_tb
// Self-checking bench for the KMP substring search unit. A directed table
// covers the empty pattern, extreme bytes, start position handling and a
// search restarted on the same pattern. Random patterns and strings over
// small alphabets follow. The last phase fills the pattern store past its
// capacity. Every accepted item goes through a behavioral KMP (nextval)
// model. Each result strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module kmp_substring_search_unit_tb;
  import kmp_pkg::*;

  localparam int MAX_PAT      = 255;
  localparam int PAT_CAP      = (MAX_PAT < LEN_MAX) ? MAX_PAT : LEN_MAX;
  localparam int RAND_ITEMS   = 600;
  localparam int DRAIN_CYCLES = 2000;   // table build of a full pattern plus fallbacks
  localparam int STALL_LIMIT  = 20000;

  // Directed row: either a start_pos write or one item, optionally with a
  // result typed in by hand
  typedef struct packed {
    logic              on;
    logic              has;
    result_t           res;
  } pin_t;

  typedef struct packed {
    logic              is_cfg;
    logic [POS_W-1:0]  cfg_val;
    cmd_t              item;
    pin_t              pin;
  } step_row_t;

  localparam pin_t NO_PIN = '0;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  cmd_t             cmd = '0;
  logic             busy;
  logic             result_valid;
  result_t          result;
  logic             cfg_we = 1'b0;
  logic [POS_W-1:0] cfg_data = '0;
  pin_t             pin_now = '0;

  // Search model state
  logic [CHAR_W-1:0] pat_mem [STORE_DEPTH];
  logic [CHAR_W-1:0] nextval [STORE_DEPTH];
  int unsigned       pat_len = 0;
  int unsigned       cmp_idx = 1;
  int unsigned       text_cnt = 0;
  bit                table_built = 1'b0;
  bit                matched = 1'b0;
  logic [POS_W-1:0]  start_reg = 16'd1;

  result_t     pending_q [$];
  int          fail_count = 0;
  int          live_items = 0;
  int          found_cnt = 0;
  int          miss_cnt = 0;
  int          cfg_cnt = 0;
  int          stall_cycles = 0;
  int          idle_pct = 20;

  kmp_substring_search_unit #(
    .MAX_PATTERN(MAX_PAT)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // KMP search step for one accepted item; returns 1 when a result follows
  function automatic bit kmp_step(input cmd_t c, output result_t r, output bit live);
    int unsigned i;
    int unsigned j;
    int unsigned first_pos;
    r = '0;
    live = 1'b1;
    first_pos = (start_reg == 0) ? 1 : 32'(start_reg);
    if (c.op == OP_PATTERN) begin
      if (table_built || matched) begin
        pat_len = 0;
        table_built = 1'b0;
        matched = 1'b0;
        text_cnt = 0;
        cmp_idx = 1;
      end
      if (pat_len < PAT_CAP) begin
        pat_len++;
        pat_mem[pat_len] = c.data_byte;
      end else begin
        live = 1'b0;
      end
      return 1'b0;
    end
    if (matched) begin
      live = 1'b0;
      return 1'b0;
    end
    // nextval table, built once per pattern
    if (!table_built) begin
      i = 1;
      j = 0;
      nextval[1] = '0;
      while (i < pat_len) begin
        if (j == 0 || pat_mem[i] == pat_mem[j]) begin
          i++;
          j++;
          if (pat_mem[i] != pat_mem[j]) nextval[i] = j[CHAR_W-1:0];
          else nextval[i] = nextval[j];
        end else begin
          j = 32'(nextval[j]);
        end
      end
      table_built = 1'b1;
    end
    if (text_cnt < 65535) text_cnt++;
    if (text_cnt >= first_pos) begin
      if (pat_len == 0) begin
        matched = 1'b1;
        r.found = 1'b1;
        r.position = text_cnt[POS_W-1:0];
        return 1'b1;
      end
      while (cmp_idx != 0 && c.data_byte != pat_mem[cmp_idx])
        cmp_idx = 32'(nextval[cmp_idx]);
      cmp_idx++;
      if (cmp_idx > pat_len) begin
        matched = 1'b1;
        r.found = 1'b1;
        r.position = 16'(text_cnt + 1 - pat_len);
        return 1'b1;
      end
    end
    if (c.last_text) begin
      text_cnt = 0;
      cmp_idx = 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Result check first, then prediction for the item taken at this edge
  always @(posedge clk) begin
    result_t want;
    result_t r;
    bit      has;
    bit      live;
    bit      progress;
    if (!rst) begin
      progress = result_valid || (start && !busy) || cfg_we;
      stall_cycles <= progress ? 0 : stall_cycles + 1;
      if (result_valid) begin
        if (result.found) found_cnt++;
        else miss_cnt++;
        if (pending_q.size() == 0) begin
          $error("unexpected result: found %0d position %0d", result.found, result.position);
          fail_count++;
        end else begin
          want = pending_q.pop_front();
          if (result.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, result.found);
            fail_count++;
          end
          if (result.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, result.position);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        has = kmp_step(cmd, r, live);
        if (live) live_items++;
        if (pin_now.on) begin
          if (pin_now.has) pending_q.push_back(pin_now.res);
        end else if (has) begin
          pending_q.push_back(r);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item, result or write
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no progress for %0d cycles", STALL_LIMIT);
    $display("FAIL kmp_substring_search_unit");
    $finish;
  end

  // Offer one item, with an optional idle gap, until it is taken
  task automatic send_item(input cmd_t c, input pin_t p);
    int gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    cmd     <= c;
    pin_now <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // start_pos write once the unit has gone quiet
  task automatic write_start_pos(input logic [POS_W-1:0] v);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    start_reg  = v;
    cfg_cnt++;
  endtask

  function automatic step_row_t cfg_row(input logic [POS_W-1:0] v);
    step_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.cfg_val = v;
    return s;
  endfunction

  function automatic step_row_t item_row(input logic op, input logic [7:0] ch,
                                         input logic last);
    step_row_t s;
    s = '0;
    s.item = '{op, ch, last};
    return s;
  endfunction

  function automatic step_row_t pinned_row(input logic op, input logic [7:0] ch,
                                           input logic last, input logic has,
                                           input logic fnd, input logic [15:0] pos);
    step_row_t s;
    s = item_row(op, ch, last);
    s.pin = '{1'b1, has, '{fnd, pos}};
    return s;
  endfunction

  initial begin
    step_row_t   dir_rows [$];
    logic [7:0]  alpha [0:2];
    logic [7:0]  pat [0:256];
    logic [7:0]  txt [0:300];
    logic        last;
    int          n_alpha;
    int          plen;
    int          tlen;
    int          off;
    int          session;
    logic [15:0] sp;

    // Empty pattern: string ends before start_pos, then a match at start_pos
    dir_rows.push_back(cfg_row(16'd2));
    dir_rows.push_back(pinned_row(OP_TEXT, 8'h61, 1'b1, 1'b1, 1'b0, 16'd0));
    dir_rows.push_back(pinned_row(OP_TEXT, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0));
    dir_rows.push_back(pinned_row(OP_TEXT, 8'hFF, 1'b0, 1'b1, 1'b1, 16'd2));
    // Nothing after a match, not even for a last byte
    dir_rows.push_back(pinned_row(OP_TEXT, 8'h7A, 1'b1, 1'b0, 1'b0, 16'd0));
    // start_pos zero acts as one; last flag on a pattern byte is ignored
    dir_rows.push_back(cfg_row(16'd0));
    dir_rows.push_back(item_row(OP_PATTERN, 8'h00, 1'b1));
    dir_rows.push_back(item_row(OP_PATTERN, 8'hFF, 1'b0));
    dir_rows.push_back(item_row(OP_PATTERN, 8'h00, 1'b0));
    // Match that ends on the last byte, after a fallback
    dir_rows.push_back(item_row(OP_TEXT, 8'h00, 1'b0));
    dir_rows.push_back(item_row(OP_TEXT, 8'hFF, 1'b0));
    dir_rows.push_back(item_row(OP_TEXT, 8'hFF, 1'b0));
    dir_rows.push_back(item_row(OP_TEXT, 8'h00, 1'b0));
    dir_rows.push_back(item_row(OP_TEXT, 8'hFF, 1'b0));
    dir_rows.push_back(item_row(OP_TEXT, 8'h00, 1'b1));
    // Periodic pattern: miss on one string, then hit on the next
    dir_rows.push_back(item_row(OP_PATTERN, 8'h61, 1'b0));
    dir_rows.push_back(item_row(OP_PATTERN, 8'h62, 1'b0));
    dir_rows.push_back(item_row(OP_PATTERN, 8'h61, 1'b0));
    dir_rows.push_back(item_row(OP_PATTERN, 8'h62, 1'b0));
    dir_rows.push_back(item_row(OP_TEXT, 8'h61, 1'b0));
    dir_rows.push_back(item_row(OP_TEXT, 8'h62, 1'b0));
    dir_rows.push_back(item_row(OP_TEXT, 8'h61, 1'b0));
    dir_rows.push_back(pinned_row(OP_TEXT, 8'h63, 1'b1, 1'b1, 1'b0, 16'd0));
    dir_rows.push_back(item_row(OP_TEXT, 8'h61, 1'b0));
    dir_rows.push_back(item_row(OP_TEXT, 8'h62, 1'b0));
    dir_rows.push_back(item_row(OP_TEXT, 8'h61, 1'b0));
    dir_rows.push_back(item_row(OP_TEXT, 8'h62, 1'b0));
    dir_rows.push_back(cfg_row(16'd1));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) write_start_pos(dir_rows[k].cfg_val);
      else send_item(dir_rows[k].item, dir_rows[k].pin);
    end

    // Random sessions: one pattern, then a few strings searched with it
    session = 0;
    while (live_items < RAND_ITEMS) begin
      idle_pct = (live_items >= 200 && live_items < 400) ? 0 : 20;
      if (session % 4 == 3) begin
        case ($urandom_range(0, 5))
          0: sp = 16'd1;
          1: sp = 16'd0;
          2: sp = 16'($urandom_range(2, 8));
          3: sp = 16'($urandom_range(2, 30));
          4: sp = 16'($urandom_range(1, 4));
          default: sp = 16'($urandom_range(100, 65535));
        endcase
        write_start_pos(sp);
      end
      n_alpha = $urandom_range(1, 3);
      for (int k = 0; k < 3; k++) alpha[k] = 8'($urandom_range(0, 255));
      plen = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
      for (int k = 0; k < plen; k++) begin
        pat[k] = ($urandom_range(99) < 10) ? 8'($urandom_range(0, 255))
                                           : alpha[$urandom_range(0, n_alpha - 1)];
        send_item('{OP_PATTERN, pat[k], 1'($urandom_range(0, 1))}, NO_PIN);
      end
      repeat ($urandom_range(1, 3)) begin
        tlen = $urandom_range(1, plen + 16);
        for (int k = 0; k < tlen; k++) txt[k] = alpha[$urandom_range(0, n_alpha - 1)];
        if (tlen >= plen && $urandom_range(99) < 60) begin
          off = $urandom_range(0, tlen - plen);
          for (int k = 0; k < plen; k++) txt[off + k] = pat[k];
        end
        for (int k = 0; k < tlen; k++) begin
          // stray pattern byte mid-string: restarts the pattern once its table is built, else appends
          if ($urandom_range(99) < 2)
            send_item('{OP_PATTERN, 8'($urandom_range(0, 255)), 1'b0}, NO_PIN);
          last = (k == tlen - 1 && $urandom_range(99) < 92) || $urandom_range(99) < 3;
          send_item('{OP_TEXT, txt[k], last}, NO_PIN);
        end
      end
      session++;
    end

    // Full pattern store: two bytes past the capacity are dropped
    idle_pct = 20;
    write_start_pos(16'd1);
    alpha[0] = 8'($urandom_range(0, 255));
    alpha[1] = ~alpha[0];
    for (int k = 0; k < PAT_CAP + 2; k++) begin
      pat[k] = alpha[$urandom_range(0, 1)];
      send_item('{OP_PATTERN, pat[k], 1'b0}, NO_PIN);
    end
    for (int k = 0; k < 5; k++) send_item('{OP_TEXT, alpha[$urandom_range(0, 1)], 1'b0}, NO_PIN);
    for (int k = 0; k < PAT_CAP; k++) begin
      send_item('{OP_TEXT, pat[k], 1'(k == PAT_CAP - 1)}, NO_PIN);
    end
    start <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d random sessions and %0d live items over %0d start_pos writes.",
             session, live_items, cfg_cnt);
    $display("Checked %0d match and %0d no-match results, %0d mismatches.",
             found_cnt, miss_cnt, fail_count);
    if (fail_count == 0) begin
      $display("PASS kmp_substring_search_unit");
    end else begin
      $display("FAIL kmp_substring_search_unit");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/kmp_pkg.sv
hw/rtl/kmp_ram.sv
hw/rtl/kmp_seq.sv
hw/rtl/kmp_substring_search_unit.sv
bench/kmp_substring_search_unit_tb.sv
